### rtl/gcd_three_method_unit_core_macros.svh
// assertion macros shared by the checker of the gcd unit
`ifndef GCD_THREE_METHOD_UNIT_CORE_MACROS_SVH
`define GCD_THREE_METHOD_UNIT_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define GTMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd unit check failed");

// next-cycle implication, off during reset
`define GTMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd unit check failed");

`endif

### rtl/gtmu_pkg.sv
// types, constants and codes shared by the gcd unit
package gtmu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SHIFT_W    = $clog2(DATA_WIDTH + 1);
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_BAD_FUNC = 2'd2
    } status_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_NONE   = 2'd0,
        FUNC_ENUM   = 2'd1,
        FUNC_EUCLID = 2'd2,
        FUNC_SUB    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SHIFT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic done;
        logic k_inc;
    } step_flags_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } ctrl_t;

endpackage

### rtl/gtmu_step.sv
// one reduction step of the binary gcd: halve, or subtract and halve
module gtmu_step
    import gtmu_pkg::*;
(
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] a_out,
    output logic [DATA_WIDTH-1:0] b_out,
    output step_flags_t           flags
);

    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] diff_neg;
    logic                  equal;
    logic                  a_gt;

    // borrow of a - b tells which operand is larger
    assign diff     = {1'b0, a} - {1'b0, b};
    assign diff_neg = ~diff[DATA_WIDTH-1:0] + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    assign equal    = (a == b);
    assign a_gt     = !diff[DATA_WIDTH] && !equal;

    always_comb
    begin
        a_out       = a;
        b_out       = b;
        flags.done  = equal;
        flags.k_inc = 1'b0;
        if (!equal)
        begin
            if (!a[0] && !b[0])
            begin
                // common factor of two, kept in the shift count
                a_out       = a >> 1;
                b_out       = b >> 1;
                flags.k_inc = 1'b1;
            end
            else if (!a[0])
            begin
                a_out = a >> 1;
            end
            else if (!b[0])
            begin
                b_out = b >> 1;
            end
            else if (a_gt)
            begin
                a_out = diff[DATA_WIDTH-1:0] >> 1;
            end
            else
            begin
                b_out = diff_neg >> 1;
            end
        end
    end

endmodule

### rtl/gcd_three_method_unit_core.sv
// Greatest common divisor unit, one shared subtract/shift step under a sequencer.
// Input channel s_*: operand_a in s_tdata[31:0], operand_b in s_tdata[63:32],
// method selector func in s_tuser. Output channel m_*: divisor in m_tdata,
// status in m_tuser (0 ok, 1 zero operand, 2 invalid selector).
// All three methods give the same divisor; every method runs on the binary
// gcd step (halve an even operand, or subtract the smaller odd one and halve).
// An item with a zero operand or selector 0 shows its result in the cycle
// after it is taken. A valid item runs reduction steps until the operands
// are seen equal, then shifts each common factor of two back in and leaves
// the shift before it shows its result.
// One item is in flight at a time: s_tready is high only while idle, and the
// next item can be taken from the cycle after the result is taken.
// A stalled receiver holds m_tvalid, m_tdata and m_tuser until m_tready.
// Reset (rst_n low, asynchronous) returns to idle and drops any pending result.
module gcd_three_method_unit_core
    import gtmu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*DATA_WIDTH-1:0] s_tdata,   // operand_a, operand_b
    input  logic [FUNC_W-1:0]       s_tuser,   // func
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_WIDTH-1:0]   m_tdata,   // divisor
    output logic [STATUS_W-1:0]     m_tuser    // status
);

    state_t                state_reg, state_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [SHIFT_W-1:0]    k_reg, k_next;
    status_t               status_reg, status_next;

    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic                  op_zero;
    logic                  func_bad;
    logic [DATA_WIDTH-1:0] step_a;
    logic [DATA_WIDTH-1:0] step_b;
    step_flags_t           flags;
    ctrl_t                 ctrl;

    assign op_a     = s_tdata[DATA_WIDTH-1:0];
    assign op_b     = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign op_zero  = (op_a == '0) || (op_b == '0);
    assign func_bad = (func_t'(s_tuser) == FUNC_NONE);

    gtmu_step u_step (
        .a     (a_reg),
        .b     (b_reg),
        .a_out (step_a),
        .b_out (step_b),
        .flags (flags)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (op_zero || func_bad) ? S_OUT : S_RUN;
                end
            end
            S_RUN:
            begin
                if (flags.done)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl     = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            S_RUN:
            begin
                ctrl.step = !flags.done;
            end
            S_SHIFT:
            begin
                ctrl.shift = (k_reg != '0);
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        status_next = status_reg;
        if (ctrl.load)
        begin
            k_next = '0;
            b_next = op_b;
            if (op_zero)
            begin
                a_next      = '0;
                status_next = ST_ZERO;
            end
            else if (func_bad)
            begin
                a_next      = '0;
                status_next = ST_BAD_FUNC;
            end
            else
            begin
                a_next      = op_a;
                status_next = ST_OK;
            end
        end
        else if (ctrl.step)
        begin
            a_next = step_a;
            b_next = step_b;
            if (flags.k_inc)
            begin
                k_next = k_reg + SHIFT_W'(1);
            end
        end
        else if (ctrl.shift)
        begin
            // put the common factors of two back
            a_next = a_reg << 1;
            k_next = k_reg - SHIFT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        status_reg <= status_next;
    end

    assign m_tdata = a_reg;
    assign m_tuser = status_reg;

endmodule

### rtl/gtmu_checker.sv
// port-level checks of the gcd unit, bound to the top level
`include "gcd_three_method_unit_core_macros.svh"

module gtmu_checker
    import gtmu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [2*DATA_WIDTH-1:0] s_tdata,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [DATA_WIDTH-1:0]   m_tdata,
    input logic [STATUS_W-1:0]     m_tuser
);

    logic s_fire;
    logic zero_in;

    assign s_fire  = s_tvalid && s_tready;
    assign zero_in = (s_tdata[DATA_WIDTH-1:0] == '0)
                  || (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == '0);

    `GTMU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `GTMU_ASSERT_NOW(a_one_in_flight, clk, rst_n, m_tvalid, !s_tready)
    `GTMU_ASSERT_NOW(a_err_zero, clk, rst_n, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `GTMU_ASSERT_NOW(a_ok_nonzero, clk, rst_n, m_tvalid && (m_tuser == ST_OK), m_tdata != '0)
    `GTMU_ASSERT_NEXT(a_zero_fast, clk, rst_n, s_fire && zero_in, m_tvalid && (m_tuser == ST_ZERO))

endmodule

bind gcd_three_method_unit_core gtmu_checker u_gtmu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
